// ===== sv/ksg_pkg.sv =====
// ----------------------------------------------------------------------------
// ksg_pkg
// Shared sizes and constants for the keyed semaphore table lookup block.
// ----------------------------------------------------------------------------
package ksg_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int PROCS   = 64;

  // index widths derived from the table geometry
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PROC_W = (PROCS > 1) ? $clog2(PROCS) : 1;

  // beat field widths
  localparam int KEY_W   = 32;
  localparam int PIDX_W  = 6;
  localparam int SLOT_W  = 6;

  // per-slot user count
  localparam int                 COUNT_W   = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ===== sv/ksg_req_if.sv =====
// ----------------------------------------------------------------------------
// ksg_req_if
// Request channel: key to find or create and the requesting process.
// ----------------------------------------------------------------------------
interface ksg_req_if
  import ksg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  sem_key;
  logic [PIDX_W-1:0] proc_index;

  modport source (output valid, output sem_key, output proc_index, input ready);
  modport sink   (input valid, input sem_key, input proc_index, output ready);
endinterface

// ===== sv/ksg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ksg_rsp_if
// Response channel: slot identifier and status flags.
// ----------------------------------------------------------------------------
interface ksg_rsp_if
  import ksg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_id;
  logic              ok;
  logic              created;

  modport source (output valid, output slot_id, output ok, output created, input ready);
  modport sink   (input valid, input slot_id, input ok, input created, output ready);
endinterface

// ===== sv/ksg_ram.sv =====
// ----------------------------------------------------------------------------
// ksg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ksg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/keyed_semaphore_table_get.sv =====
// ----------------------------------------------------------------------------
// keyed_semaphore_table_get
// Find-or-create lookup of a keyed semaphore table.
//
// Usage:
//   req  carries sem_key and proc_index; one beat per request.
//   rsp  returns slot_id, ok and created; one beat per request, in order.
//   The key memory is scanned from slot 0 upward, one slot per cycle, through
//   its registered read port; the scan stops at the first active slot holding
//   the key. Without a match the lowest inactive slot seen is claimed. A hit
//   or claim then reads the user count and membership row of that slot in
//   ST_UPD_RD and writes them back in ST_UPD_WR. A full table answers with
//   ok low. One request is in work at a time, so the next beat is taken after
//   the response loads.
//   req.ready is high only while no request is in work; a finished response
//   sits in the output register, so a new request is taken while rsp stalls.
//   A second finished response waits until the output register drains.
//   Reset marks every slot inactive; key, count and membership memories need
//   no clearing since their contents are only used for slots already claimed.
// ----------------------------------------------------------------------------
module keyed_semaphore_table_get
  import ksg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ksg_req_if.sink     req,
  ksg_rsp_if.source   rsp
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPD_RD = 3'd2;
  localparam logic [2:0] ST_UPD_WR = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [2:0]         state;
  logic [ENTRIES-1:0] active;
  logic [KEY_W-1:0]   key_q;
  logic [PROC_W-1:0]  proc_q;
  logic [IDX_W-1:0]   scan_idx;
  logic               cmp_v;
  logic [IDX_W-1:0]   cmp_idx;
  logic               free_v;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   slot;
  logic               made;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_ok;
  logic               res_created;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_ok;
  logic               out_created;

  logic [KEY_W-1:0]   key_rd;
  logic [COUNT_W-1:0] cnt_rd;
  logic [PROCS-1:0]   row_rd;
  logic [COUNT_W-1:0] cnt_next;
  logic [PROCS-1:0]   row_next;
  logic               upd_we;
  logic               key_we;
  logic               hit;
  logic               cur_free;
  logic               at_last;
  logic               out_free;

  // key store, read at the scan pointer
  ksg_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot),
    .wdata (key_q),
    .raddr (scan_idx),
    .rdata (key_rd)
  );

  // user count store
  ksg_ram #(.WIDTH(COUNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (slot),
    .wdata (cnt_next),
    .raddr (slot),
    .rdata (cnt_rd)
  );

  // membership rows, one bit per process
  ksg_ram #(.WIDTH(PROCS), .DEPTH(ENTRIES)) u_row_ram (
    .clk   (clk),
    .we    (upd_we),
    .waddr (slot),
    .wdata (row_next),
    .raddr (slot),
    .rdata (row_rd)
  );

  // compare stage of the scan
  assign hit      = cmp_v && active[cmp_idx] && (key_rd == key_q);
  assign cur_free = cmp_v && !active[cmp_idx];
  assign at_last  = cmp_v && (cmp_idx == LAST_IDX);

  // read-modify-write of the claimed or found slot
  assign upd_we   = (state == ST_UPD_WR);
  assign key_we   = upd_we && made;
  assign cnt_next = made ? COUNT_W'(1) :
                    ((cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1));
  assign row_next = (made ? '0 : row_rd) | (PROCS'(1) << proc_q);

  assign out_free = !out_valid || rsp.ready;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      cmp_v     <= 1'b0;
      free_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished response, clear on a taken beat
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cmp_v <= 1'b0;
          if (req.valid) begin
            key_q    <= req.sem_key;
            proc_q   <= PROC_W'(req.proc_index);
            scan_idx <= '0;
            free_v   <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_v   <= 1'b1;
          cmp_idx <= scan_idx;
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
          if (hit) begin
            slot  <= cmp_idx;
            made  <= 1'b0;
            state <= ST_UPD_RD;
          end else begin
            if (cur_free && !free_v) begin
              free_v   <= 1'b1;
              free_idx <= cmp_idx;
            end
            if (at_last) begin
              if (free_v || cur_free) begin
                slot  <= free_v ? free_idx : cmp_idx;
                made  <= 1'b1;
                state <= ST_UPD_RD;
              end else begin
                res_slot    <= '0;
                res_ok      <= 1'b0;
                res_created <= 1'b0;
                state       <= ST_DONE;
              end
            end
          end
        end
        ST_UPD_RD: begin
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          active[slot] <= 1'b1;
          res_slot     <= SLOT_W'(slot);
          res_ok       <= 1'b1;
          res_created  <= made;
          state        <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_slot    <= res_slot;
            out_ok      <= res_ok;
            out_created <= res_created;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.slot_id = out_slot;
  assign rsp.ok      = out_ok;
  assign rsp.created = out_created;

endmodule

// ===== sv/ksg_checker.sv =====
// ----------------------------------------------------------------------------
// ksg_checker
// Port-level checks for the keyed semaphore table lookup, bound to the top.
// ----------------------------------------------------------------------------
module ksg_checker
  import ksg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [SLOT_W-1:0] rsp_slot_id,
  input logic              rsp_ok,
  input logic              rsp_created
);

  // one request in work: no beat can follow directly
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in work");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!rsp_valid && req_ready))
    else $error("block not idle after reset");

  // a failed lookup reports no slot and no creation
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (!rsp_created && (rsp_slot_id == '0)))
    else $error("failed response carries slot data");

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_slot_id) && $stable(rsp_ok) && $stable(rsp_created)))
    else $error("response changed while stalled");

endmodule

bind keyed_semaphore_table_get ksg_checker u_ksg_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_slot_id (rsp.slot_id),
  .rsp_ok      (rsp.ok),
  .rsp_created (rsp.created)
);

// ===== tb/sv/keyed_semaphore_table_get_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_semaphore_table_get_tb
// Self-checking bench for the find-or-create semaphore table lookup. A short
// table of hand-picked requests runs first. A random stream follows that
// fills the table, hammers one hot key past the user count limit, and then
// mixes hits on every slot with misses on a full table. Every response beat
// is compared, field by field and in order, with typed rows or a table model.
// Both channels are paced through free-running, sparse-sender, stalling-
// receiver and mixed phases. One long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module keyed_semaphore_table_get_tb;
  import ksg_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1280;
  localparam int PHASE_ITEMS   = 160;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 80;
  localparam int DIRECTED_ROWS = 17;

  typedef enum int {PACE_FREE, PACE_SPARSE_SEND, PACE_SLOW_RECV, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_id;
    logic              ok;
    logic              created;
  } grant_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [PIDX_W-1:0] proc;
    bit                typed;
    logic [SLOT_W-1:0] slot_id;
    logic              ok;
    logic              created;
  } probe_t;

  logic clk;
  logic rst;

  ksg_req_if req_ch ();
  ksg_rsp_if rsp_ch ();

  keyed_semaphore_table_get dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the semaphore table
  bit                 tbl_active  [ENTRIES];
  logic [KEY_W-1:0]   tbl_key     [ENTRIES];
  logic [COUNT_W-1:0] tbl_users   [ENTRIES];
  logic [PROCS-1:0]   tbl_members [ENTRIES];
  int                 slots_used;

  grant_t grants_due [$];
  probe_t probes [DIRECTED_ROWS];
  pace_t  pace;
  bit     hold_rsp;
  int     requests_sent;
  int     mismatches;
  int     cycle_count;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // find the key among active slots, else claim the lowest free slot
  function automatic grant_t lookup_or_claim(input logic [KEY_W-1:0]  key,
                                             input logic [PIDX_W-1:0] proc);
    grant_t g;
    int     hit;
    int     i;
    g   = '0;
    hit = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_active[i] && tbl_key[i] == key) hit = i;
    end
    if (hit < 0) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && !tbl_active[i]) begin
          hit           = i;
          tbl_active[i] = 1'b1;
          tbl_key[i]    = key;
          tbl_users[i]  = '0;
          g.created     = 1'b1;
          slots_used++;
        end
      end
    end
    // full table: failure, nothing changes
    if (hit < 0) return g;
    tbl_members[hit][proc % PROCS] = 1'b1;
    if (tbl_users[hit] != COUNT_MAX) tbl_users[hit] = tbl_users[hit] + COUNT_W'(1);
    g.slot_id = hit[SLOT_W-1:0];
    g.ok      = 1'b1;
    return g;
  endfunction

  function automatic int send_idle_pct();
    case (pace)
      PACE_SPARSE_SEND: return 82;
      PACE_BOTH:        return 12;
      default:          return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (pace)
      PACE_SLOW_RECV: return 82;
      PACE_BOTH:      return 12;
      default:        return 0;
    endcase
  endfunction

  // offer one request beat and log its expected grant once accepted
  task automatic offer_request(input logic [KEY_W-1:0]  key,
                               input logic [PIDX_W-1:0] proc,
                               input bit                typed,
                               input grant_t            typed_grant);
    grant_t predicted;
    while ($urandom_range(99) < send_idle_pct()) begin
      req_ch.valid      <= 1'b0;
      req_ch.sem_key    <= $urandom;
      req_ch.proc_index <= PIDX_W'($urandom_range(PROCS - 1));
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.sem_key    <= key;
    req_ch.proc_index <= proc;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = lookup_or_claim(key, proc);
    grants_due.push_back(typed ? typed_grant : predicted);
    requests_sent++;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
  endtask

  // response side: check each beat, then pick the next ready value
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (grants_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat slot_id %0d ok %0b created %0b", $time,
                 rsp_ch.slot_id, rsp_ch.ok, rsp_ch.created);
      end else begin
        want = grants_due.pop_front();
        if (rsp_ch.slot_id !== want.slot_id)
          report_field("slot_id", int'(want.slot_id), int'(rsp_ch.slot_id));
        if (rsp_ch.ok !== want.ok)
          report_field("ok", int'(want.ok), int'(rsp_ch.ok));
        if (rsp_ch.created !== want.created)
          report_field("created", int'(want.created), int'(rsp_ch.created));
      end
    end
    rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct());
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_rsp = 1'b0;
    wait (requests_sent >= HOLD_AT);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // stimulus
  initial begin
    grant_t           typed_grant;
    logic [KEY_W-1:0] key;
    int               pick;
    int               n;

    // rows: key, proc, typed, slot_id, ok, created
    probes = '{
      '{32'h0000_0000, 6'd0,  1'b1, 6'd0, 1'b1, 1'b1},
      '{32'hFFFF_FFFF, 6'd63, 1'b1, 6'd1, 1'b1, 1'b1},
      '{32'h0000_0000, 6'd63, 1'b1, 6'd0, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 6'd0,  1'b1, 6'd1, 1'b1, 1'b0},
      '{32'h0000_0000, 6'd0,  1'b1, 6'd0, 1'b1, 1'b0},
      '{32'h0000_0000, 6'd0,  1'b1, 6'd0, 1'b1, 1'b0},
      '{32'h8000_0000, 6'd21, 1'b1, 6'd2, 1'b1, 1'b1},
      '{32'h0000_0001, 6'd42, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 6'd1,  1'b0, 6'd0, 1'b0, 1'b0},
      '{32'hFFFF_FFFE, 6'd62, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h8000_0000, 6'd32, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 6'd31, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, 6'd7,  1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h5555_5555, 6'd56, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h5555_5555, 6'd56, 1'b0, 6'd0, 1'b0, 1'b0},
      '{32'h0000_0001, 6'd0,  1'b0, 6'd0, 1'b0, 1'b0},
      '{32'hFFFF_FFFE, 6'd63, 1'b0, 6'd0, 1'b0, 1'b0}
    };

    slots_used    = 0;
    requests_sent = 0;
    pace          = PACE_FREE;
    for (n = 0; n < ENTRIES; n++) begin
      tbl_active[n]  = 1'b0;
      tbl_key[n]     = '0;
      tbl_users[n]   = '0;
      tbl_members[n] = '0;
    end

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.sem_key    <= '0;
    req_ch.proc_index <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      typed_grant = '{probes[n].slot_id, probes[n].ok, probes[n].created};
      offer_request(probes[n].key, probes[n].proc, probes[n].typed, typed_grant);
    end

    // random stream: fill the table, then hits everywhere and misses when full
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pace = pace_t'((n / PHASE_ITEMS) % 4);
      pick = $urandom_range(99);
      if (slots_used < ENTRIES) begin
        if (pick < 45)      key = $urandom;
        else if (pick < 70) key = tbl_key[$urandom_range(slots_used - 1)];
        else                key = tbl_key[0];
      end else begin
        if (pick < 30)      key = tbl_key[0];
        else if (pick < 75) key = tbl_key[$urandom_range(ENTRIES - 1)];
        else                key = $urandom;
      end
      offer_request(key, PIDX_W'($urandom_range(PROCS - 1)), 1'b0, '0);
    end

    // drain
    req_ch.valid <= 1'b0;
    pace = PACE_FREE;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
